FILE: rtl/srf_pkg.sv
// Shared types and constants for the scanner reply framer.
// No dependencies; every other file of the block but srf_if.sv imports this package.
`default_nettype none

package srf_pkg;

    // Input operations.
    localparam logic [1:0] OP_BYTE  = 2'd0;
    localparam logic [1:0] OP_TICK  = 2'd1;
    localparam logic [1:0] OP_START = 2'd2;
    localparam logic [1:0] OP_STOP  = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] CFG_HOST_MODE = 2'd0;
    localparam logic [1:0] CFG_IDLE_GAP  = 2'd1;
    localparam logic [1:0] CFG_SCAN_TMO  = 2'd2;

    // Result kinds.
    localparam logic [3:0] KIND_BARCODE  = 4'd0;
    localparam logic [3:0] KIND_FAILED   = 4'd1;
    localparam logic [3:0] KIND_TRIGGER  = 4'd2;
    localparam logic [3:0] KIND_CONFIG   = 4'd3;
    localparam logic [3:0] KIND_TIMEOUT  = 4'd4;
    localparam logic [3:0] KIND_OVERFLOW = 4'd5;
    localparam logic [3:0] KIND_DROPPED  = 4'd6;
    localparam logic [3:0] KIND_STARTED  = 4'd7;
    localparam logic [3:0] KIND_STOPPED  = 4'd8;

    // Reply signature bytes.
    localparam logic [7:0] BYTE_CONFIG  = 8'h22;
    localparam logic [7:0] BYTE_TRIGGER = 8'h24;
    localparam logic [7:0] BYTE_FAIL0   = 8'h33;
    localparam logic [7:0] BYTE_FAIL1   = 8'h75;
    localparam logic [7:0] BYTE_FAIL2   = 8'h02;
    localparam logic [7:0] BYTE_TRIG1   = 8'h61;
    localparam logic [7:0] BYTE_TRIG2   = 8'h41;

    // Register reset values and limits.
    localparam logic [7:0]  IDLE_GAP_RESET = 8'd20;
    localparam logic [7:0]  IDLE_MAX       = 8'hFF;
    localparam logic [16:0] ELAPSED_MAX    = 17'h1FFFF;

    // Widths that cover the largest supported buffer.
    localparam int LEN_W  = 7;
    localparam int ADDR_W = 6;
    localparam int QUEUE_DEPTH = 4;

    // One unit of work handed from the front to the back.
    typedef struct packed {
        logic             is_drain;   // emit the buffered bytes as a barcode
        logic             tail_tmo;   // a timeout result follows the main one
        logic [3:0]       kind;
        logic [7:0]       data;
        logic [7:0]       aux;
        logic             scanning;
        logic [LEN_W-1:0] len;        // barcode length for a drain
    } t_job;

    // Buffer write port from the front into the back's memory.
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } t_memwr;

endpackage

`default_nettype wire

FILE: rtl/srf_if.sv
// Handshake channel interfaces of the scanner reply framer.
// Input items, result items and configuration writes; no dependencies.
`default_nettype none

interface srf_item_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [7:0] rx_byte;

    modport source (output valid, operation, rx_byte, input ready);
    modport sink   (input valid, operation, rx_byte, output ready);
endinterface

interface srf_result_if;
    logic       valid;
    logic       ready;
    logic [3:0] kind;
    logic [7:0] data_byte;
    logic [7:0] aux_byte;
    logic       last;
    logic       scanning;

    modport source (output valid, kind, data_byte, aux_byte, last, scanning, input ready);
    modport sink   (input valid, kind, data_byte, aux_byte, last, scanning, output ready);
endinterface

interface srf_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/srf_fifo.sv
// Short job queue between the front and the back of the framer.
// Depends on srf_pkg for the job type and the queue depth.
`default_nettype none

module srf_fifo
    import srf_pkg::*;
(
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_push,
    input  t_job i_data,
    output logic o_full,
    input  wire  i_pop,
    output t_job o_data,
    output logic o_empty
);

    localparam int PW = $clog2(QUEUE_DEPTH);

    t_job            r_mem [QUEUE_DEPTH];
    logic [PW-1:0]   r_wr, r_rd;
    logic [PW:0]     r_cnt;

    assign o_full  = (r_cnt == (PW+1)'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push && !o_full) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop && !o_empty) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({i_push && !o_full, i_pop && !o_empty})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (PW+1)'(QUEUE_DEPTH))
        else $error("job queue count out of range");

    a_pop_moves_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pop && !o_empty) |=> (r_rd == $past(r_rd) + 1'b1))
        else $error("job queue read pointer did not advance");

    a_full_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_full && !i_pop) |=> o_full)
        else $error("job queue lost an entry while full");

endmodule

`default_nettype wire

FILE: rtl/srf_front.sv
// Front of the framer: accepts items and configuration writes, keeps the
// buffer count, reply head bytes and scan timers, and issues jobs.
// Depends on srf_pkg and the channel interfaces in srf_if.sv.
`default_nettype none

module srf_front
    import srf_pkg::*;
#(
    parameter int BUFFER_DEPTH = 64
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    srf_item_if.sink     i_item,
    srf_cfg_if.sink      i_cfg,
    output t_job         o_job,
    output logic         o_job_push,
    input  wire          i_q_full,
    output t_memwr       o_memwr,
    input  wire          i_drain_done
);

    localparam int CW = $clog2(BUFFER_DEPTH + 1);

    logic [CW-1:0] r_count, n_count;
    logic [7:0]    r_head [4];
    logic [7:0]    r_idle, n_idle;
    logic          r_manual, n_manual;
    logic [16:0]   r_elapsed, n_elapsed;
    logic          r_host, n_host;
    logic [7:0]    r_gap, n_gap;
    logic [15:0]   r_tmo, n_tmo;
    logic          r_drain_busy;

    logic          accept;
    logic          has_result;
    logic [7:0]    h [4];

    assign i_cfg.ready  = 1'b1;
    assign i_item.ready = !i_q_full && !r_drain_busy;
    assign accept       = i_item.valid && i_item.ready;
    assign o_job_push   = accept && has_result;

    // Head bytes as they stand once the incoming byte is in place.
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            h[i] = (r_count == CW'(i)) ? i_item.rx_byte : r_head[i];
        end
    end

    always_comb begin
        logic [CW-1:0] cnt_inc;
        logic          drop_head;

        cnt_inc    = r_count + 1'b1;
        drop_head  = (r_head[0] == BYTE_CONFIG) || (r_head[0] == BYTE_TRIGGER)
                     || (r_head[0] == BYTE_FAIL0);
        n_count    = r_count;
        n_idle     = r_idle;
        n_manual   = r_manual;
        n_elapsed  = r_elapsed;
        n_host     = r_host;
        n_gap      = r_gap;
        n_tmo      = r_tmo;
        has_result = 1'b0;
        o_job      = '0;
        o_memwr    = '0;

        if (accept) begin
            unique case (i_item.operation)
                OP_BYTE: begin
                    n_idle = '0;
                    if (r_count == CW'(BUFFER_DEPTH)) begin
                        n_count    = '0;
                        has_result = 1'b1;
                        o_job.kind = KIND_OVERFLOW;
                    end else begin
                        o_memwr.en   = 1'b1;
                        o_memwr.addr = ADDR_W'(r_count);
                        o_memwr.data = i_item.rx_byte;
                        n_count      = cnt_inc;
                        if (r_count >= CW'(2) && h[0] == BYTE_FAIL0 && h[1] == BYTE_FAIL1
                            && h[2] == BYTE_FAIL2) begin
                            n_manual   = 1'b0;
                            n_elapsed  = '0;
                            n_count    = '0;
                            has_result = 1'b1;
                            o_job.kind = KIND_FAILED;
                        end else if (r_count >= CW'(3) && h[0] == BYTE_TRIGGER
                                     && h[1] == BYTE_TRIG1 && h[2] == BYTE_TRIG2) begin
                            n_count    = '0;
                            has_result = 1'b1;
                            o_job.kind = KIND_TRIGGER;
                            o_job.data = h[3];
                        end else if (r_count >= CW'(2) && h[0] == BYTE_CONFIG) begin
                            n_count    = '0;
                            has_result = 1'b1;
                            o_job.kind = KIND_CONFIG;
                            o_job.data = h[1];
                            o_job.aux  = h[2];
                        end
                    end
                end
                OP_TICK: begin
                    if (r_idle != IDLE_MAX) begin
                        n_idle = r_idle + 1'b1;
                    end
                    if (r_count != '0 && n_idle >= r_gap) begin
                        n_count    = '0;
                        has_result = 1'b1;
                        if (drop_head) begin
                            o_job.kind = KIND_DROPPED;
                        end else begin
                            o_job.is_drain = 1'b1;
                            o_job.kind     = KIND_BARCODE;
                            o_job.len      = LEN_W'(r_count);
                            n_manual       = 1'b0;
                            n_elapsed      = '0;
                        end
                    end
                    if (n_manual) begin
                        if (n_elapsed != ELAPSED_MAX) begin
                            n_elapsed = n_elapsed + 1'b1;
                        end
                        if (r_tmo != '0 && n_elapsed > {1'b0, r_tmo}) begin
                            n_manual  = 1'b0;
                            n_elapsed = '0;
                            // A dropped result raised by this same tick gets the timeout behind it.
                            if (has_result) begin
                                o_job.tail_tmo = 1'b1;
                            end else begin
                                o_job.kind = KIND_TIMEOUT;
                            end
                            has_result = 1'b1;
                        end
                    end
                end
                OP_START: begin
                    if (r_host && !r_manual) begin
                        n_manual   = 1'b1;
                        n_elapsed  = '0;
                        has_result = 1'b1;
                        o_job.kind = KIND_STARTED;
                    end
                end
                OP_STOP: begin
                    if (r_host && r_manual) begin
                        n_manual   = 1'b0;
                        n_elapsed  = '0;
                        n_count    = '0;
                        has_result = 1'b1;
                        o_job.kind = KIND_STOPPED;
                    end
                end
                default: begin
                    n_count = r_count;
                end
            endcase
        end

        o_job.scanning = n_manual || !r_host;

        if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.index)
                CFG_HOST_MODE: begin
                    if (i_cfg.data[0] != r_host) begin
                        n_host    = i_cfg.data[0];
                        n_manual  = 1'b0;
                        n_elapsed = '0;
                    end
                end
                CFG_IDLE_GAP: n_gap = i_cfg.data[7:0];
                CFG_SCAN_TMO: n_tmo = i_cfg.data;
                default:      n_gap = r_gap;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_memwr.en && r_count < CW'(4)) begin
            r_head[r_count[1:0]] <= i_item.rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_idle       <= '0;
            r_manual     <= 1'b0;
            r_elapsed    <= '0;
            r_host       <= 1'b1;
            r_gap        <= IDLE_GAP_RESET;
            r_tmo        <= '0;
            r_drain_busy <= 1'b0;
        end else begin
            r_count   <= n_count;
            r_idle    <= n_idle;
            r_manual  <= n_manual;
            r_elapsed <= n_elapsed;
            r_host    <= n_host;
            r_gap     <= n_gap;
            r_tmo     <= n_tmo;
            if (o_job_push && o_job.is_drain) begin
                r_drain_busy <= 1'b1;
            end else if (i_drain_done) begin
                r_drain_busy <= 1'b0;
            end
        end
    end

    a_busy_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_drain_busy |-> !i_item.ready)
        else $error("item taken while a barcode drain owns the buffer");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(BUFFER_DEPTH))
        else $error("buffer count beyond depth");

    a_done_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_drain_done |-> r_drain_busy)
        else $error("drain finished with none pending");

    a_elapsed_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_manual |-> (r_elapsed == '0))
        else $error("scan timer running outside a manual scan");

endmodule

`default_nettype wire

FILE: rtl/srf_back.sv
// Back of the framer: owns the receive buffer memory, pops jobs and drives
// the result channel through an output register.
// Depends on srf_pkg and the result interface in srf_if.sv.
`default_nettype none

module srf_back
    import srf_pkg::*;
#(
    parameter int BUFFER_DEPTH = 64
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  t_job         i_job,
    input  wire          i_q_empty,
    output logic         o_pop,
    input  t_memwr       i_memwr,
    output logic         o_drain_done,
    srf_result_if.source o_result
);

    localparam int IW = $clog2(BUFFER_DEPTH);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EMIT = 4'b0010,
        S_TAIL = 4'b0100,
        S_READ = 4'b1000
    } t_state;

    t_state        r_state, n_state;
    t_job          r_job;
    logic [IW-1:0] r_idx, n_idx;
    logic [7:0]    r_mem [BUFFER_DEPTH];
    logic [7:0]    r_rd_data;
    logic          rd_en;
    logic [IW-1:0] rd_addr;

    logic          r_ov;
    logic [3:0]    r_kind;
    logic [7:0]    r_data, r_aux;
    logic          r_last, r_scan;
    logic          out_free, load;
    logic [3:0]    ld_kind;
    logic [7:0]    ld_data, ld_aux;
    logic          ld_last;
    logic          byte_last;

    assign out_free  = !r_ov || o_result.ready;
    assign byte_last = (LEN_W'(r_idx) + LEN_W'(1)) == r_job.len;

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        o_pop        = 1'b0;
        o_drain_done = 1'b0;
        rd_en        = 1'b0;
        rd_addr      = '0;
        load         = 1'b0;
        ld_kind      = r_job.kind;
        ld_data      = r_job.data;
        ld_aux       = r_job.aux;
        ld_last      = !r_job.tail_tmo;

        unique case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    o_pop = 1'b1;
                    if (i_job.is_drain) begin
                        rd_en   = 1'b1;
                        n_idx   = '0;
                        n_state = S_READ;
                    end else begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    load    = 1'b1;
                    n_state = r_job.tail_tmo ? S_TAIL : S_IDLE;
                end
            end
            S_TAIL: begin
                if (out_free) begin
                    load    = 1'b1;
                    ld_kind = KIND_TIMEOUT;
                    ld_data = '0;
                    ld_aux  = '0;
                    ld_last = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_READ: begin
                if (out_free) begin
                    load    = 1'b1;
                    ld_kind = KIND_BARCODE;
                    ld_data = r_rd_data;
                    ld_aux  = '0;
                    ld_last = byte_last;
                    if (byte_last) begin
                        o_drain_done = 1'b1;
                        n_state      = S_IDLE;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        rd_en   = 1'b1;
                        rd_addr = r_idx + 1'b1;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_memwr.en) begin
            r_mem[i_memwr.addr[IW-1:0]] <= i_memwr.data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
        if (o_pop) begin
            r_job <= i_job;
        end
        if (load) begin
            r_kind <= ld_kind;
            r_data <= ld_data;
            r_aux  <= ld_aux;
            r_last <= ld_last;
            r_scan <= r_job.scanning;
        end
        r_idx <= n_idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load) begin
                r_ov <= 1'b1;
            end else if (o_result.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign o_result.valid     = r_ov;
    assign o_result.kind      = r_kind;
    assign o_result.data_byte = r_data;
    assign o_result.aux_byte  = r_aux;
    assign o_result.last      = r_last;
    assign o_result.scanning  = r_scan;

    a_pop_idle_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (r_state == S_IDLE))
        else $error("job popped while another is in progress");

    a_done_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_drain_done |=> (r_ov && r_last && r_kind == KIND_BARCODE))
        else $error("drain ended without a final barcode byte");

    a_no_write_in_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> !i_memwr.en)
        else $error("buffer written during a drain");

endmodule

`default_nettype wire

FILE: rtl/scanner_reply_framer.sv
// Scanner reply framer. Each item is handled by the front in the cycle it is
// accepted; a reply, status or dropped result reaches the output register
// through a four-entry job queue, so the front can take new items while the
// back still emits earlier ones, as long as the queue has room. A barcode
// drain reads the receive buffer memory one byte per cycle while the output
// register is free, and no new item is accepted from the tick that ends the
// barcode until its last byte has been loaded into the output register.
// Results wait in that register, so the output side may stall freely.
// The buffer memory needs no clearing pass after reset.
// Depends on srf_pkg, srf_if, srf_fifo, srf_front and srf_back.
`default_nettype none

module scanner_reply_framer
    import srf_pkg::*;
#(
    parameter int BUFFER_DEPTH = 64
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    srf_item_if.sink     i_item,
    srf_cfg_if.sink      i_cfg,
    srf_result_if.source o_result
);

    t_job   job_in, job_out;
    t_memwr memwr;
    logic   job_push, q_full, q_empty, pop, drain_done;

    srf_front #(.BUFFER_DEPTH(BUFFER_DEPTH)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (i_item),
        .i_cfg        (i_cfg),
        .o_job        (job_in),
        .o_job_push   (job_push),
        .i_q_full     (q_full),
        .o_memwr      (memwr),
        .i_drain_done (drain_done)
    );

    srf_fifo u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_data  (job_in),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_data  (job_out),
        .o_empty (q_empty)
    );

    srf_back #(.BUFFER_DEPTH(BUFFER_DEPTH)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job        (job_out),
        .i_q_empty    (q_empty),
        .o_pop        (pop),
        .i_memwr      (memwr),
        .o_drain_done (drain_done),
        .o_result     (o_result)
    );

endmodule

`default_nettype wire
